[rtl/itp_pkg.sv]
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int KIND_W = 4;
    localparam int ERR_W  = 2;
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int PREC_W = 3;
    localparam int NUM_OPS = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [KIND_W-1:0] K_SYMBOL = 4'd2;
    localparam logic [KIND_W-1:0] K_FUNC   = 4'd3;
    localparam logic [KIND_W-1:0] K_ADD    = 4'd4;
    localparam logic [KIND_W-1:0] K_POW    = 4'd8;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd9;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd10;
    localparam logic [KIND_W-1:0] K_END    = 4'd11;

    localparam logic [ERR_W-1:0] E_NONE = 2'd0;
    localparam logic [ERR_W-1:0] E_UNK  = 2'd1;
    localparam logic [ERR_W-1:0] E_MISM = 2'd2;
    localparam logic [ERR_W-1:0] E_OVF  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PREC_ADD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_SUB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_MUL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_DIV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREC_POW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RASSOC   = 3'd5;

    typedef struct packed {
        logic [NUM_OPS-1:0][PREC_W-1:0] prec;
        logic [NUM_OPS-1:0]             rassoc;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [VALUE_WIDTH-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [VALUE_WIDTH-1:0] value;
        logic [ERR_W-1:0]       err;
    } t_res;

    typedef struct packed {
        logic                   we;
        logic [AW-1:0]          waddr;
        t_entry                 wdata;
        logic                   re;
        logic [AW-1:0]          raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PUSH,
        S_FUNC,
        S_ERR,
        S_DONE
    } t_state;

    function automatic logic is_op(input logic [KIND_W-1:0] kind);
        return (kind >= K_ADD) && (kind <= K_POW);
    endfunction

    function automatic logic [PREC_W-1:0] prec_of(input t_cfg cfg,
                                                  input logic [KIND_W-1:0] kind);
        logic [KIND_W-1:0] d;
        d = kind - K_ADD;
        if (d < KIND_W'(NUM_OPS)) begin
            return cfg.prec[d[2:0]];
        end
        return '0;
    endfunction

    function automatic logic right_assoc(input t_cfg cfg, input logic [KIND_W-1:0] kind);
        logic [KIND_W-1:0] d;
        d = kind - K_ADD;
        if (d < KIND_W'(NUM_OPS)) begin
            return cfg.rassoc[d[2:0]];
        end
        return 1'b0;
    endfunction

endpackage

[rtl/itp_if.sv]
`timescale 1ns / 1ps

interface itp_tok_if;
    logic                                valid;
    logic                                ready;
    logic [itp_pkg::KIND_W-1:0]          token_kind;
    logic [itp_pkg::VALUE_WIDTH-1:0]     token_value;

    modport source (output valid, output token_kind, output token_value, input ready);
    modport sink   (input valid, input token_kind, input token_value, output ready);
endinterface

interface itp_res_if;
    logic                                valid;
    logic                                ready;
    logic [itp_pkg::KIND_W-1:0]          out_kind;
    logic [itp_pkg::VALUE_WIDTH-1:0]     out_value;
    logic                                last_of_run;
    logic [itp_pkg::ERR_W-1:0]           error_code;

    modport source (output valid, output out_kind, output out_value, output last_of_run,
                    output error_code, input ready);
    modport sink   (input valid, input out_kind, input out_value, input last_of_run,
                    input error_code, output ready);
endinterface

[rtl/infix_to_postfix_token_reorder_core.sv]
`timescale 1ns / 1ps

// Shunting-yard infix to postfix reorder. Tokens come in on i_tok one transfer at a time and
// leave in postfix order on o_res; last_of_run marks the final result of each input token
// and error_code flags unknown kinds, an unmatched right paren and stack overflow. The operator
// stack lives in a RAM with one registered read port, and only one token is in work at a time.
// Values, unknown kinds, functions, left parens and operators that meet an empty stack are
// handled straight from idle. An operator, right paren or end token on a non-empty stack first
// issues the top read, then examines or pops entries (each pop re-reads the new top), then
// pushes and hands off the final result; a right paren also looks below its left paren when
// entries remain there, and reports the mismatch when it finds no left paren. Output stalls
// hold the steps that emit a result.
// Precedence and associativity are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while idle, since the block itself does not enforce it.
module infix_to_postfix_token_reorder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [itp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    itp_tok_if.sink                         i_tok,
    itp_res_if.source                       o_res
);
    import itp_pkg::*;

    t_cfg     r_cfg;
    t_ram_req w_ram_req;
    t_entry   w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prec[0] <= PREC_W'(1);
            r_cfg.prec[1] <= PREC_W'(1);
            r_cfg.prec[2] <= PREC_W'(2);
            r_cfg.prec[3] <= PREC_W'(2);
            r_cfg.prec[4] <= PREC_W'(3);
            r_cfg.rassoc  <= NUM_OPS'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PREC_ADD: r_cfg.prec[0] <= i_cfg_data[PREC_W-1:0];
                CFG_PREC_SUB: r_cfg.prec[1] <= i_cfg_data[PREC_W-1:0];
                CFG_PREC_MUL: r_cfg.prec[2] <= i_cfg_data[PREC_W-1:0];
                CFG_PREC_DIV: r_cfg.prec[3] <= i_cfg_data[PREC_W-1:0];
                CFG_PREC_POW: r_cfg.prec[4] <= i_cfg_data[PREC_W-1:0];
                CFG_RASSOC:   r_cfg.rassoc  <= i_cfg_data[NUM_OPS-1:0];
                default: begin
                end
            endcase
        end
    end

    itp_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_ram_req.we),
        .i_waddr(w_ram_req.waddr),
        .i_wdata(w_ram_req.wdata),
        .i_re   (w_ram_req.re),
        .i_raddr(w_ram_req.raddr),
        .o_rdata(w_ram_rdata)
    );

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_tok      (i_tok),
        .o_res      (o_res),
        .o_ram_req  (w_ram_req),
        .i_ram_rdata(w_ram_rdata)
    );

endmodule

[rtl/itp_ram.sv]
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/itp_ctrl.sv]
`timescale 1ns / 1ps

module itp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itp_pkg::t_cfg     i_cfg,
    itp_tok_if.sink           i_tok,
    itp_res_if.source         o_res,
    output itp_pkg::t_ram_req o_ram_req,
    input  itp_pkg::t_entry   i_ram_rdata
);
    import itp_pkg::*;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic                   r_pend_vld, n_pend_vld;
    t_res                   r_pend, n_pend;
    logic                   r_out_vld, n_out_vld;
    t_res                   r_out, n_out;
    logic                   r_out_last, n_out_last;

    logic             w_out_free;
    logic             w_can_emit;
    logic             w_acc;
    logic             w_full;
    logic             w_pops;
    logic             w_cnt_zero;
    logic             w_dec_zero;
    logic [CNT_W-1:0] w_cnt_dec;
    logic [CNT_W-1:0] w_cnt_dec2;
    logic [KIND_W-1:0] w_in_kind;
    t_entry           w_top;
    t_ram_req         w_ram;

    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_can_emit = !r_pend_vld || w_out_free;
    assign i_tok.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_tok.valid && i_tok.ready;
    assign w_in_kind  = i_tok.token_kind;
    assign w_full     = (r_cnt == CNT_W'(STACK_DEPTH));
    assign w_cnt_zero = (r_cnt == '0);
    assign w_cnt_dec  = r_cnt - CNT_W'(1);
    assign w_cnt_dec2 = r_cnt - CNT_W'(2);
    assign w_dec_zero = (w_cnt_dec == '0);
    assign w_top      = i_ram_rdata;
    assign w_pops     = is_op(w_top.kind) &&
                        ((prec_of(i_cfg, w_top.kind) > prec_of(i_cfg, r_kind)) ||
                         ((prec_of(i_cfg, w_top.kind) == prec_of(i_cfg, r_kind)) &&
                          !right_assoc(i_cfg, r_kind)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && !w_cnt_zero &&
                    (is_op(w_in_kind) || w_in_kind == K_RPAREN || w_in_kind == K_END)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (is_op(r_kind)) begin
                    if (w_pops) begin
                        if (w_can_emit) begin
                            n_state = w_dec_zero ? S_PUSH : S_READ;
                        end
                    end else if (!w_full || w_can_emit) begin
                        n_state = S_DONE;
                    end
                end else if (r_kind == K_RPAREN) begin
                    if (w_top.kind == K_LPAREN) begin
                        n_state = w_dec_zero ? S_DONE : S_FUNC;
                    end else if (w_can_emit) begin
                        n_state = w_dec_zero ? S_ERR : S_READ;
                    end
                end else if (r_kind == K_END) begin
                    if (w_can_emit) begin
                        n_state = w_dec_zero ? S_DONE : S_READ;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUSH: begin
                n_state = S_DONE;
            end
            S_FUNC: begin
                if (w_top.kind != K_FUNC || w_can_emit) begin
                    n_state = S_DONE;
                end
            end
            S_ERR: begin
                if (w_can_emit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pend_vld || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and stack access
    always_comb begin
        t_res em;
        logic do_emit;
        logic do_direct;
        logic do_flush;

        em         = '0;
        do_emit    = 1'b0;
        do_direct  = 1'b0;
        do_flush   = 1'b0;
        n_cnt      = r_cnt;
        n_kind     = r_kind;
        n_value    = r_value;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out      = r_out;
        n_out_last = r_out_last;
        w_ram      = '0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_kind  = w_in_kind;
                    n_value = i_tok.token_value;
                    if (w_in_kind <= K_SYMBOL) begin
                        do_direct = 1'b1;
                        em        = '{kind: w_in_kind, value: i_tok.token_value, err: E_NONE};
                    end else if (w_in_kind == K_FUNC || w_in_kind == K_LPAREN ||
                                 (is_op(w_in_kind) && w_cnt_zero)) begin
                        if (w_full) begin
                            do_direct = 1'b1;
                            em = '{kind: w_in_kind, value: i_tok.token_value, err: E_OVF};
                        end else begin
                            w_ram.we    = 1'b1;
                            w_ram.waddr = r_cnt[AW-1:0];
                            w_ram.wdata = '{kind: w_in_kind, value: i_tok.token_value};
                            n_cnt       = r_cnt + CNT_W'(1);
                        end
                    end else if (is_op(w_in_kind) || w_in_kind == K_RPAREN ||
                                 w_in_kind == K_END) begin
                        if (!w_cnt_zero) begin
                            w_ram.re    = 1'b1;
                            w_ram.raddr = w_cnt_dec[AW-1:0];
                        end else if (w_in_kind == K_RPAREN) begin
                            do_direct = 1'b1;
                            em = '{kind: w_in_kind, value: i_tok.token_value, err: E_MISM};
                        end
                    end else begin
                        do_direct = 1'b1;
                        em        = '{kind: w_in_kind, value: i_tok.token_value, err: E_UNK};
                    end
                end
            end
            S_READ: begin
                if (is_op(r_kind)) begin
                    if (w_pops) begin
                        if (w_can_emit) begin
                            do_emit = 1'b1;
                            em      = '{kind: w_top.kind, value: w_top.value, err: E_NONE};
                            n_cnt   = w_cnt_dec;
                            if (!w_dec_zero) begin
                                w_ram.re    = 1'b1;
                                w_ram.raddr = w_cnt_dec2[AW-1:0];
                            end
                        end
                    end else if (w_full) begin
                        if (w_can_emit) begin
                            do_emit = 1'b1;
                            em      = '{kind: r_kind, value: r_value, err: E_OVF};
                        end
                    end else begin
                        w_ram.we    = 1'b1;
                        w_ram.waddr = r_cnt[AW-1:0];
                        w_ram.wdata = '{kind: r_kind, value: r_value};
                        n_cnt       = r_cnt + CNT_W'(1);
                    end
                end else if (r_kind == K_RPAREN) begin
                    if (w_top.kind == K_LPAREN) begin
                        n_cnt = w_cnt_dec;
                        if (!w_dec_zero) begin
                            w_ram.re    = 1'b1;
                            w_ram.raddr = w_cnt_dec2[AW-1:0];
                        end
                    end else if (w_can_emit) begin
                        do_emit = 1'b1;
                        em      = '{kind: w_top.kind, value: w_top.value, err: E_NONE};
                        n_cnt   = w_cnt_dec;
                        if (!w_dec_zero) begin
                            w_ram.re    = 1'b1;
                            w_ram.raddr = w_cnt_dec2[AW-1:0];
                        end
                    end
                end else if (r_kind == K_END) begin
                    if (w_can_emit) begin
                        do_emit = 1'b1;
                        em      = '{kind: w_top.kind, value: w_top.value, err: E_NONE};
                        n_cnt   = w_cnt_dec;
                        if (!w_dec_zero) begin
                            w_ram.re    = 1'b1;
                            w_ram.raddr = w_cnt_dec2[AW-1:0];
                        end
                    end
                end
            end
            S_PUSH: begin
                w_ram.we    = 1'b1;
                w_ram.waddr = r_cnt[AW-1:0];
                w_ram.wdata = '{kind: r_kind, value: r_value};
                n_cnt       = r_cnt + CNT_W'(1);
            end
            S_FUNC: begin
                if (w_top.kind == K_FUNC && w_can_emit) begin
                    do_emit = 1'b1;
                    em      = '{kind: w_top.kind, value: w_top.value, err: E_NONE};
                    n_cnt   = w_cnt_dec;
                end
            end
            S_ERR: begin
                if (w_can_emit) begin
                    do_emit = 1'b1;
                    em      = '{kind: r_kind, value: r_value, err: E_MISM};
                end
            end
            S_DONE: begin
                if (r_pend_vld && w_out_free) begin
                    do_flush = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // results of a run wait in r_pend so the final one can carry last
        if (do_emit) begin
            if (r_pend_vld) begin
                n_out_vld  = 1'b1;
                n_out      = r_pend;
                n_out_last = 1'b0;
            end
            n_pend_vld = 1'b1;
            n_pend     = em;
        end
        if (do_flush) begin
            n_out_vld  = 1'b1;
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_pend_vld = 1'b0;
        end
        if (do_direct) begin
            n_out_vld  = 1'b1;
            n_out      = em;
            n_out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_ram_req         = w_ram;
    assign o_res.valid       = r_out_vld;
    assign o_res.out_kind    = r_out.kind;
    assign o_res.out_value   = r_out.value;
    assign o_res.error_code  = r_out.err;
    assign o_res.last_of_run = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_vld)
        else $error("pending result left over at idle");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram.we && w_ram.re))
        else $error("stack read and write in one cycle");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.err != E_NONE |-> r_out_last)
        else $error("error result not last of its run");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_FUNC) |-> !w_cnt_zero)
        else $error("stack top examined on empty stack");

endmodule
